/* sv/isbba_pkg.sv */
package isbba_pkg;

   typedef struct packed {
      logic        mode;
      logic        is_superblock;
      logic [17:0] index;
      logic [63:0] value;
   } req_type;

   typedef struct packed {
      logic [63:0] read_value;
      logic [1:0]  status;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLR,
      ST_IDLE,
      ST_PRE,
      ST_DIV,
      ST_MUL,
      ST_OFF,
      ST_CHK,
      ST_RD0,
      ST_RD1,
      ST_EXEC,
      ST_WR1,
      ST_DONE
   } state_type;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_RANGE     = 2'd1;
   localparam logic [1:0] STATUS_TOO_WIDE  = 2'd2;

   localparam logic [7:0] CSR_SB_COUNT  = 8'd0;
   localparam logic [7:0] CSR_SB_WIDTH  = 8'd1;
   localparam logic [7:0] CSR_BPS       = 8'd2;
   localparam logic [7:0] CSR_BLK_WIDTH = 8'd3;

   localparam int IDX_W = 18;
   localparam int BPS_W = 11;

endpackage

/* sv/isbba_div.sv */
module isbba_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [isbba_pkg::IDX_W-1:0] dividend,
   input  logic [isbba_pkg::BPS_W-1:0] divisor,
   output logic                        done,
   output logic [isbba_pkg::IDX_W-1:0] quot,
   output logic [isbba_pkg::BPS_W-1:0] rem
);

   // restoring divider, one quotient bit per cycle
   logic [isbba_pkg::IDX_W-1:0] quo_ff, quo_in;
   logic [isbba_pkg::BPS_W-1:0] rem_ff, rem_in;
   logic [isbba_pkg::BPS_W-1:0] dsr_ff, dsr_in;
   logic [4:0]                  cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [isbba_pkg::BPS_W:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[isbba_pkg::IDX_W-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = 5'(isbba_pkg::IDX_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits the divisor width
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = isbba_pkg::BPS_W'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[isbba_pkg::IDX_W-2:0], 1'b1};
         end else begin
            rem_in = trial[isbba_pkg::BPS_W-1:0];
            quo_in = {quo_ff[isbba_pkg::IDX_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;
   assign rem  = rem_ff;

endmodule

/* sv/interleaved_superblock_block_array_top.sv */
// sequence: setup, division (the 18-step divider, block entries only), multiply,
// offset, check, two word reads, then the extract or the first word write; a write
// spanning two words adds the second word write; a failing check skips to the result
// throughput: one transaction at a time, the next taken once the result is in the output register
// reset: synchronous; afterwards a clearing pass zeroes the store, one word per
// cycle across all STORE_WORDS words, before the first transaction is taken
module interleaved_superblock_block_array_top #(
   parameter int STORE_WORDS = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  isbba_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output isbba_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int AW = $clog2(STORE_WORDS);
   localparam logic [36:0] TotalBits = 37'(STORE_WORDS) << 6;

   // configuration
   logic [18:0] cnt_reg_ff;
   logic [6:0]  sbw_reg_ff, bw_reg_ff;
   logic [10:0] bps_reg_ff;
   logic [18:0] cnt_c;
   logic [6:0]  sbw_c, bw_c;
   logic [10:0] bps_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_reg_ff <= 19'd1;
         sbw_reg_ff <= 7'd32;
         bps_reg_ff <= 11'd1;
         bw_reg_ff  <= 7'd16;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            isbba_pkg::CSR_SB_COUNT:  cnt_reg_ff <= csr_wdata[18:0];
            isbba_pkg::CSR_SB_WIDTH:  sbw_reg_ff <= csr_wdata[6:0];
            isbba_pkg::CSR_BPS:       bps_reg_ff <= csr_wdata[10:0];
            isbba_pkg::CSR_BLK_WIDTH: bw_reg_ff  <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign cnt_c = (cnt_reg_ff > 19'd262144) ? 19'd262144 : cnt_reg_ff;
   assign sbw_c = (sbw_reg_ff == 7'd0) ? 7'd1 : ((sbw_reg_ff > 7'd64) ? 7'd64 : sbw_reg_ff);
   assign bw_c  = (bw_reg_ff == 7'd0) ? 7'd1 : ((bw_reg_ff > 7'd64) ? 7'd64 : bw_reg_ff);
   assign bps_c = (bps_reg_ff == 11'd0) ? 11'd1 :
                  ((bps_reg_ff > 11'd1024) ? 11'd1024 : bps_reg_ff);

   // store
   logic [63:0]   mem [STORE_WORDS];
   logic          we;
   logic [AW-1:0] waddr, raddr;
   logic [63:0]   wdata, rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   // sequencer
   isbba_pkg::state_type state_ff, state_in;
   isbba_pkg::req_type   req_ff, req_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [6:0]    sbw_ff, sbw_in, bw_ff, bw_in, w_ff, w_in;
   logic [18:0]   cnt_ff, cnt_in;
   logic [16:0]   bpsbw_ff, bpsbw_in, rec_ff, rec_in;
   logic [29:0]   limit_ff, limit_in;
   logic [34:0]   prodq_ff, prodq_in;
   logic [17:0]   prodr_ff, prodr_in;
   logic [35:0]   off_ff, off_in;
   logic          idx_err_ff, idx_err_in;
   logic [AW-1:0] word_ff, word_in;
   logic [7:0]    sh_ff, sh_in;
   logic          span_ff, span_in;
   logic [63:0]   mask_ff, mask_in;
   logic [63:0]   w0_ff, w0_in, w1new_ff, w1new_in;
   isbba_pkg::rsp_type res_ff, res_in, rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic                div_start, div_done;
   logic [17:0]         div_q;
   logic [10:0]         div_r;
   logic [36:0]         end_bits;
   logic [63:0]         mask_c;
   logic [127:0]        pair, ins, merged, extracted;

   isbba_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_ff.index),
      .divisor  (bps_c),
      .done     (div_done),
      .quot     (div_q),
      .rem      (div_r)
   );

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      clr_in       = clr_ff;
      sbw_in       = sbw_ff;
      bw_in        = bw_ff;
      w_in         = w_ff;
      cnt_in       = cnt_ff;
      bpsbw_in     = bpsbw_ff;
      rec_in       = rec_ff;
      limit_in     = limit_ff;
      prodq_in     = prodq_ff;
      prodr_in     = prodr_ff;
      off_in       = off_ff;
      idx_err_in   = idx_err_ff;
      word_in      = word_ff;
      sh_in        = sh_ff;
      span_in      = span_ff;
      mask_in      = mask_ff;
      w0_in        = w0_ff;
      w1new_in     = w1new_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      div_start    = 1'b0;
      we           = 1'b0;
      waddr        = word_ff;
      wdata        = '0;
      raddr        = word_ff;
      req_stall    = 1'b1;
      end_bits     = {1'b0, off_ff} + 37'(w_ff);
      mask_c       = ~({64{1'b1}} << w_ff);
      pair         = {w0_ff, rdata_ff};
      ins          = {64'd0, req_ff.value} << sh_ff;
      merged       = pair | ins;
      extracted    = pair >> sh_ff;

      unique case (state_ff)
         isbba_pkg::ST_CLR: begin
            we     = 1'b1;
            waddr  = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(STORE_WORDS - 1)) begin
               state_in = isbba_pkg::ST_IDLE;
            end
         end
         isbba_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               req_in   = req_data;
               state_in = isbba_pkg::ST_PRE;
            end
         end
         isbba_pkg::ST_PRE: begin
            sbw_in    = sbw_c;
            bw_in     = bw_c;
            cnt_in    = cnt_c;
            bpsbw_in  = 17'(bps_c * bw_c);
            limit_in  = 30'(cnt_c * bps_c);
            div_start = !req_ff.is_superblock;
            state_in  = isbba_pkg::ST_DIV;
         end
         isbba_pkg::ST_DIV: begin
            rec_in = 17'(sbw_ff) + bpsbw_ff;
            if (req_ff.is_superblock || div_done) begin
               state_in = isbba_pkg::ST_MUL;
            end
         end
         isbba_pkg::ST_MUL: begin
            if (req_ff.is_superblock) begin
               prodq_in = 35'(req_ff.index * rec_ff);
               prodr_in = '0;
            end else begin
               prodq_in = 35'(div_q * rec_ff);
               prodr_in = 18'(div_r * bw_ff);
            end
            state_in = isbba_pkg::ST_OFF;
         end
         isbba_pkg::ST_OFF: begin
            if (req_ff.is_superblock) begin
               off_in     = {1'b0, prodq_ff};
               w_in       = sbw_ff;
               idx_err_in = {1'b0, req_ff.index} >= cnt_ff;
            end else begin
               off_in     = {1'b0, prodq_ff} + 36'(sbw_ff) + 36'(prodr_ff);
               w_in       = bw_ff;
               idx_err_in = 30'(req_ff.index) >= limit_ff;
            end
            state_in = isbba_pkg::ST_CHK;
         end
         isbba_pkg::ST_CHK: begin
            word_in = off_ff[AW+5:6];
            sh_in   = 8'd128 - {2'b00, off_ff[5:0]} - {1'b0, w_ff};
            span_in = ({1'b0, off_ff[5:0]} + w_ff) > 7'd64;
            mask_in = mask_c;
            res_in.read_value = '0;
            res_in.status     = isbba_pkg::STATUS_OK;
            if (idx_err_ff || end_bits > TotalBits) begin
               res_in.status = isbba_pkg::STATUS_RANGE;
               state_in      = isbba_pkg::ST_DONE;
            end else if (req_ff.mode && ((req_ff.value & ~mask_c) != '0)) begin
               res_in.status = isbba_pkg::STATUS_TOO_WIDE;
               state_in      = isbba_pkg::ST_DONE;
            end else begin
               state_in = isbba_pkg::ST_RD0;
            end
         end
         isbba_pkg::ST_RD0: begin
            raddr    = word_ff;
            state_in = isbba_pkg::ST_RD1;
         end
         isbba_pkg::ST_RD1: begin
            w0_in    = rdata_ff;
            raddr    = word_ff + 1'b1;
            state_in = isbba_pkg::ST_EXEC;
         end
         isbba_pkg::ST_EXEC: begin
            if (req_ff.mode) begin
               we       = 1'b1;
               waddr    = word_ff;
               wdata    = merged[127:64];
               w1new_in = merged[63:0];
               state_in = span_ff ? isbba_pkg::ST_WR1 : isbba_pkg::ST_DONE;
            end else begin
               res_in.read_value = extracted[63:0] & mask_ff;
               state_in          = isbba_pkg::ST_DONE;
            end
         end
         isbba_pkg::ST_WR1: begin
            we       = 1'b1;
            waddr    = word_ff + 1'b1;
            wdata    = w1new_ff;
            state_in = isbba_pkg::ST_DONE;
         end
         isbba_pkg::ST_DONE: begin
            // hand off once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = isbba_pkg::ST_IDLE;
            end
         end
         default: state_in = isbba_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= isbba_pkg::ST_CLR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff     <= req_in;
      sbw_ff     <= sbw_in;
      bw_ff      <= bw_in;
      w_ff       <= w_in;
      cnt_ff     <= cnt_in;
      bpsbw_ff   <= bpsbw_in;
      rec_ff     <= rec_in;
      limit_ff   <= limit_in;
      prodq_ff   <= prodq_in;
      prodr_ff   <= prodr_in;
      off_ff     <= off_in;
      idx_err_ff <= idx_err_in;
      word_ff    <= word_in;
      sh_ff      <= sh_in;
      span_ff    <= span_in;
      mask_ff    <= mask_in;
      w0_ff      <= w0_in;
      w1new_ff   <= w1new_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == isbba_pkg::ST_CLR |-> req_stall)
      else $error("transaction taken during clearing pass");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == isbba_pkg::ST_DIV)
      else $error("divider finished outside division step");

   a_write_only_ok: assert property (@(posedge clock) disable iff (reset)
      (we && state_ff != isbba_pkg::ST_CLR) |-> (req_ff.mode && !idx_err_ff &&
      res_ff.status == isbba_pkg::STATUS_OK))
      else $error("store written for a failing transaction");

   a_second_word_span: assert property (@(posedge clock) disable iff (reset)
      state_ff == isbba_pkg::ST_WR1 |-> span_ff && $past(state_ff) == isbba_pkg::ST_EXEC)
      else $error("second word written without a spanning entry");

endmodule

/* verif/interleaved_superblock_block_array_top_tb.sv */
module interleaved_superblock_block_array_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_WORDS = 4096;

   class entry_scoreboard;
      bit [18:0] sb_count;
      bit [6:0]  sbw_reg;
      bit [10:0] bps_reg;
      bit [6:0]  blk_width;
      bit [63:0] bit_store [STORE_WORDS];
      isbba_pkg::rsp_type pending_rsp [$];
      int        mismatches;

      function void clear();
         sb_count = 1;
         sbw_reg = 32;
         bps_reg = 1;
         blk_width = 16;
         foreach (bit_store[i]) bit_store[i] = '0;
         pending_rsp.delete();
         mismatches = 0;
      endfunction

      function void set_reg(logic [7:0] idx, logic [31:0] data);
         case (idx)
            isbba_pkg::CSR_SB_COUNT:  sb_count = data[18:0];
            isbba_pkg::CSR_SB_WIDTH:  sbw_reg = data[6:0];
            isbba_pkg::CSR_BPS:       bps_reg = data[10:0];
            isbba_pkg::CSR_BLK_WIDTH: blk_width = data[6:0];
            default: ;
         endcase
      endfunction

      function longint unsigned clampv(longint unsigned v, longint unsigned lo,
                                       longint unsigned hi);
         if (v < lo) return lo;
         if (v > hi) return hi;
         return v;
      endfunction

      function bit [63:0] low_mask(int unsigned w);
         return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
      endfunction

      function void note_request(isbba_pkg::req_type rq);
         longint unsigned cnt, sbw, bps, bw, rec, w, off, lim, idx, pos, rt;
         int unsigned word;
         bit [63:0] mask, r;
         isbba_pkg::rsp_type e;
         cnt = clampv(sb_count, 0, 262144);
         sbw = clampv(sbw_reg, 1, 64);
         bps = clampv(bps_reg, 1, 1024);
         bw = clampv(blk_width, 1, 64);
         rec = sbw + bps * bw;
         idx = rq.index;
         e = '0;
         if (rq.is_superblock) begin
            lim = cnt;
            w = sbw;
            off = idx * rec;
         end else begin
            lim = cnt * bps;
            w = bw;
            off = (idx / bps) * rec + sbw + (idx % bps) * bw;
         end
         mask = low_mask(w);
         word = off >> 6;
         pos = off & 63;
         if (idx >= lim || off + w > STORE_WORDS * 64) begin
            e.status = isbba_pkg::STATUS_RANGE;
         end else if (rq.mode) begin
            if (rq.value > mask) begin
               e.status = isbba_pkg::STATUS_TOO_WIDE;
            end else if (pos + w <= 64) begin
               bit_store[word] |= rq.value << (64 - pos - w);
            end else begin
               rt = pos + w - 64;
               bit_store[word] |= rq.value >> rt;
               bit_store[word + 1] |= rq.value << (64 - rt);
            end
         end else begin
            if (pos + w <= 64) begin
               r = (bit_store[word] >> (64 - pos - w)) & mask;
            end else begin
               rt = pos + w - 64;
               r = (bit_store[word] & low_mask(64 - pos)) << rt;
               r |= bit_store[word + 1] >> (64 - rt);
            end
            e.read_value = r;
         end
         pending_rsp.push_back(e);
      endfunction

      function void check_response(isbba_pkg::rsp_type got);
         isbba_pkg::rsp_type e;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
            return;
         end
         e = pending_rsp.pop_front();
         if (got.read_value !== e.read_value || got.status !== e.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected value %h status %0d, got value %h status %0d",
                        e.read_value, e.status, got.read_value, got.status);
         end
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   isbba_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   isbba_pkg::rsp_type rsp_data;
   logic    csr_valid = 0;
   logic    csr_ready;
   logic [7:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   entry_scoreboard sb;
   bit quiet_tail = 0;

   interleaved_superblock_block_array_top #(.STORE_WORDS(STORE_WORDS)) u_top (.*);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
   end

   // random stall bursts on the result side
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 19);
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
            rsp_stall <= 0;
         end
      end
   end

   // leaves csr_valid high so that writes can follow back to back
   task automatic write_reg(logic [7:0] idx, logic [31:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, data);
   endtask

   task automatic send_request(bit m, bit issb, logic [17:0] idx, logic [63:0] val);
      isbba_pkg::req_type rq;
      rq.mode = m;
      rq.is_superblock = issb;
      rq.index = idx;
      rq.value = val;
      req_valid <= 1;
      req_data <= rq;
      do @(posedge clock); while (req_stall);
      sb.note_request(rq);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [63:0] rand_value(int unsigned w);
      logic [63:0] v;
      v = {$urandom, $urandom};
      if ($urandom_range(0, 9) == 0) return v;
      return (w >= 64) ? v : v & ((64'd1 << w) - 64'd1);
   endfunction

   task automatic set_layout(logic [31:0] cnt, logic [31:0] sbw, logic [31:0] bps,
                             logic [31:0] bw);
      write_reg(isbba_pkg::CSR_SB_COUNT, cnt);
      write_reg(isbba_pkg::CSR_SB_WIDTH, sbw);
      write_reg(isbba_pkg::CSR_BPS, bps);
      write_reg(isbba_pkg::CSR_BLK_WIDTH, bw);
      csr_valid <= 0;
   endtask

   task automatic random_phase(int n);
      int unsigned sbw, bw, lim_sb, lim_blk, kind;
      logic [17:0] idx;
      bit issb;
      sbw = (sb.sbw_reg == 0) ? 1 : (sb.sbw_reg > 64 ? 64 : sb.sbw_reg);
      bw = (sb.blk_width == 0) ? 1 : (sb.blk_width > 64 ? 64 : sb.blk_width);
      lim_sb = sb.sb_count;
      lim_blk = sb.sb_count * ((sb.bps_reg == 0) ? 1 : sb.bps_reg);
      for (int i = 0; i < n; i++) begin
         issb = $urandom_range(0, 1);
         kind = $urandom_range(0, 9);
         if (kind == 0) idx = $urandom;
         else if (kind == 1) idx = issb ? lim_sb : lim_blk;
         else idx = $urandom_range(0, ((issb ? lim_sb : lim_blk) > 0 ?
                                       (issb ? lim_sb : lim_blk) - 1 : 0));
         send_request($urandom_range(0, 1), issb, idx, rand_value(issb ? sbw : bw));
      end
      drain();
   endtask

   initial begin
      sb = new();
      sb.clear();
      repeat (10) @(posedge clock);
      reset <= 0;
      // directed: reset layout, widths at the edges, errors
      send_request(1, 1, 0, 64'hFFFF_FFFF);
      send_request(0, 1, 0, 0);
      send_request(1, 0, 0, 64'hABCD);
      send_request(0, 0, 0, '1);
      send_request(1, 0, 0, 64'h1_0000);
      send_request(0, 1, 1, 0);
      send_request(1, 0, 18'h3FFFF, 0);
      drain();
      set_layout(262144, 64, 1024, 64);
      send_request(1, 1, 0, '1);
      send_request(0, 1, 0, 0);
      send_request(1, 0, 5, 64'h8000_0000_0000_0001);
      send_request(0, 0, 5, 0);
      send_request(0, 1, 18'h3FFFF, 0);
      send_request(0, 0, 4000, 0);
      drain();
      set_layout(0, 0, 0, 0);
      send_request(0, 1, 0, 0);
      send_request(1, 0, 0, 0);
      drain();
      set_layout(32'h7FFFF, 127, 2047, 127);
      send_request(1, 1, 0, 64'h1234);
      send_request(0, 0, 0, 0);
      drain();
      set_layout(1000, 1, 1, 1);
      send_request(1, 0, 3, 1);
      send_request(0, 0, 3, 0);
      send_request(1, 1, 3, 2);
      drain();
      set_layout(5000, 37, 3, 29);
      random_phase(300);
      set_layout(600, 64, 7, 63);
      random_phase(300);
      set_layout(262144, 1, 1024, 1);
      random_phase(250);
      set_layout(1200, 13, 2, 50);
      random_phase(250);
      set_layout(3, 64, 1, 64);
      random_phase(150);
      quiet_tail = 1;
      set_layout(8000, 17, 5, 9);
      random_phase(300);
      if (sb.mismatches == 0 && sb.pending_rsp.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #3ms;
      $display("FAIL");
      $finish;
   end

endmodule

/* files.f */
sv/isbba_pkg.sv
sv/isbba_div.sv
sv/interleaved_superblock_block_array_top.sv
verif/interleaved_superblock_block_array_top_tb.sv
